### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

### rtl/whtr_pkg.sv
`default_nettype none

package whtr_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int NUM_W = 5;
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_HIT     = 2'd0;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [ST_W-1:0] ST_ADDED   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLICK = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } t_rect;

endpackage

`default_nettype wire

### rtl/window_hit_test_raise.sv
// sequence: an add, or a click on an empty stack, goes straight to done; a click examines
//   windows top down (order entry, rectangle, compare), a raise moves each entry above the hit
//   one down (read, write) and puts the hit window on top; a held output stalls the done state
// flow: one transaction at a time; a new input is taken once the previous result
//   sits in the output register
// reset: synchronous active-low i_rst_n clears the window count, fsm and output valid;
`default_nettype none

`include "assert_macros.svh"

module window_hit_test_raise
    import whtr_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input channel
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire                   i_cmd,
    input  wire  [COORD_BITS-1:0] i_left_x,
    input  wire  [COORD_BITS-1:0] i_top_y,
    input  wire  [COORD_BITS-1:0] i_right_x,
    input  wire  [COORD_BITS-1:0] i_bottom_y,
    input  wire  [COORD_BITS-1:0] i_point_x,
    input  wire  [COORD_BITS-1:0] i_point_y,
    // output channel
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [NUM_W-1:0]      o_window_number
);

    // rectangle and order memories are not cleared and only live entries are ever read

    // fsm codes
    localparam logic [2:0] S_IDLE    = 3'd0;  // waiting for a transaction
    localparam logic [2:0] S_RD_ORD  = 3'd1;  // read window index at stack position
    localparam logic [2:0] S_RD_RECT = 3'd2;  // read that window's rectangle
    localparam logic [2:0] S_CMP     = 3'd3;  // point-in-rectangle test
    localparam logic [2:0] S_SH_RD   = 3'd4;  // raise: read entry above
    localparam logic [2:0] S_SH_WR   = 3'd5;  // raise: write it one place down
    localparam logic [2:0] S_FIN     = 3'd6;  // raise: put hit window on top
    localparam logic [2:0] S_DONE    = 3'd7;  // hand result to output register

    // state memories: rectangles by window index, z-order by stack position
    t_rect           rect_mem  [MAX_WINDOWS];
    logic [IDX_W-1:0] order_mem [MAX_WINDOWS];

    // control registers
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos,   n_pos;     // positions still to examine, top down
    logic [CNT_W-1:0] r_k,     n_k;       // raise cursor
    logic             r_out_valid, n_out_valid;

    // payload registers
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [ST_W-1:0]       r_res_status, n_res_status;
    logic [NUM_W-1:0]      r_res_number, n_res_number;
    logic [ST_W-1:0]       r_out_status, n_out_status;
    logic [NUM_W-1:0]      r_out_number, n_out_number;

    // memory read data, registered
    logic [IDX_W-1:0] r_ord_q;
    t_rect            r_rect_q;

    // memory port controls
    logic             ord_re, ord_we, rect_re, rect_we;
    logic [IDX_W-1:0] ord_raddr, ord_waddr, ord_wdata;
    logic [IDX_W-1:0] rect_waddr;
    t_rect            rect_wdata;

    logic             in_take;
    logic             out_take;
    logic             out_free;
    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] k_p1;
    logic             hit;

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_window_number = r_out_number;

    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign pos_m1 = r_pos - CNT_W'(1);
    assign k_p1   = r_k + CNT_W'(1);

    // inclusive bounds on all four sides; an inverted rectangle never matches
    assign hit = (r_px >= r_rect_q.x0) && (r_px <= r_rect_q.x1)
              && (r_py >= r_rect_q.y0) && (r_py <= r_rect_q.y1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_k          = r_k;
        n_px         = r_px;
        n_py         = r_py;
        n_hit_idx    = r_hit_idx;
        n_res_status = r_res_status;
        n_res_number = r_res_number;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_number = r_out_number;

        ord_re     = 1'b0;
        ord_raddr  = pos_m1[IDX_W-1:0];
        ord_we     = 1'b0;
        ord_waddr  = r_k[IDX_W-1:0];
        ord_wdata  = r_ord_q;
        rect_re    = 1'b0;
        rect_we    = 1'b0;
        rect_waddr = r_count[IDX_W-1:0];
        rect_wdata = '{x0: i_left_x, y0: i_top_y, x1: i_right_x, y1: i_bottom_y};

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_px = i_point_x;
                    n_py = i_point_y;
                    if (i_cmd == CMD_ADD) begin
                        n_state = S_DONE;
                        if (r_count == CNT_W'(MAX_WINDOWS)) begin
                            n_res_status = ST_FULL;
                            n_res_number = '0;
                        end else begin
                            // new window goes on top, numbered from 1
                            rect_we      = 1'b1;
                            ord_we       = 1'b1;
                            ord_waddr    = r_count[IDX_W-1:0];
                            ord_wdata    = r_count[IDX_W-1:0];
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = ST_ADDED;
                            n_res_number = NUM_W'(r_count + CNT_W'(1));
                        end
                    end else begin
                        n_pos        = r_count;
                        n_res_status = ST_IGNORED;
                        n_res_number = '0;
                        n_state      = (r_count == '0) ? S_DONE : S_RD_ORD;
                    end
                end
            end
            S_RD_ORD: begin
                ord_re  = 1'b1;
                n_pos   = pos_m1;
                n_state = S_RD_RECT;
            end
            S_RD_RECT: begin
                rect_re = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_hit_idx    = r_ord_q;
                    n_k          = r_pos;
                    n_res_status = ST_HIT;
                    n_res_number = NUM_W'(CNT_W'(r_ord_q) + CNT_W'(1));
                    // already on top: order stays as it is
                    n_state      = (r_pos + CNT_W'(1) < r_count) ? S_SH_RD : S_DONE;
                end else begin
                    n_state = (r_pos == '0) ? S_DONE : S_RD_ORD;
                end
            end
            S_SH_RD: begin
                ord_re    = 1'b1;
                ord_raddr = k_p1[IDX_W-1:0];
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[IDX_W-1:0];
                ord_wdata = r_ord_q;
                n_k       = k_p1;
                n_state   = (k_p1 + CNT_W'(1) < r_count) ? S_SH_RD : S_FIN;
            end
            S_FIN: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[IDX_W-1:0];
                ord_wdata = r_hit_idx;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_number = r_res_number;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_hit_idx    <= n_hit_idx;
        r_res_status <= n_res_status;
        r_res_number <= n_res_number;
        r_out_status <= n_out_status;
        r_out_number <= n_out_number;
    end

    // z-order memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            r_ord_q <= order_mem[ord_raddr];
        end
    end

    // rectangle memory: addressed by window index
    always_ff @(posedge i_clk) begin
        if (rect_we) begin
            rect_mem[rect_waddr] <= rect_wdata;
        end
        if (rect_re) begin
            r_rect_q <= rect_mem[r_ord_q];
        end
    end

    // window count never passes the stack depth
    `ASSERT_NEVER(a_count_max, r_count > CNT_W'(MAX_WINDOWS), "window count beyond stack depth")

    // a taken transaction closes the input until its result is registered
    `ASSERT_IMPL(a_busy_after_take, in_take |=> o_stall, "input open right after a transaction")

    // the count moves only on an add taken in idle
    `ASSERT_IMPL(a_count_in_idle, r_count != $past(r_count) |-> $past(r_state) == S_IDLE,
                 "window count changed outside idle")

    // a reported hit names a live window
    `ASSERT_IMPL(a_hit_number, o_valid && o_status == ST_HIT
                 |-> o_window_number != '0 && CNT_W'(o_window_number) <= r_count,
                 "hit reports a window that does not exist")

endmodule

`default_nettype wire

### verif/window_hit_test_raise_test.sv
`timescale 1ns / 1ps

module window_hit_test_raise_test;
    import whtr_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // one expected reply of the block
    typedef struct {
        logic [ST_W-1:0]  status;
        logic [NUM_W-1:0] number;
    } reply_t;

    // z-ordered window stack, mirrored at transaction level
    class window_stack;
        t_rect       rects[MAX_WINDOWS];
        int unsigned order[MAX_WINDOWS];
        int          live;
        reply_t      replies_due[$];
        int          errors;
        int          n_added, n_full, n_hit, n_raised, n_miss;

        function new();
            live = 0;
            errors = 0;
            n_added = 0;
            n_full = 0;
            n_hit = 0;
            n_raised = 0;
            n_miss = 0;
        endfunction

        task report_mismatch(input string msg);
            if (errors < 30)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // work out the reply of one accepted command and update the stack
        function void apply_command(input logic cmd, input t_rect r,
                                    input logic [COORD_BITS-1:0] px,
                                    input logic [COORD_BITS-1:0] py);
            reply_t      rep;
            int          pos;
            int          k;
            int unsigned idx;
            rep.number = '0;
            if (cmd == CMD_ADD) begin
                if (live == MAX_WINDOWS) begin
                    rep.status = ST_FULL;
                    n_full++;
                end else begin
                    rects[live] = r;
                    order[live] = live;
                    live++;
                    rep.number = NUM_W'(live);
                    rep.status = ST_ADDED;
                    n_added++;
                end
            end else begin
                rep.status = ST_IGNORED;
                for (pos = live - 1; pos >= 0; pos--) begin
                    idx = order[pos];
                    if (px >= rects[idx].x0 && px <= rects[idx].x1 &&
                        py >= rects[idx].y0 && py <= rects[idx].y1) begin
                        if (pos != live - 1)
                            n_raised++;
                        for (k = pos; k < live - 1; k++)
                            order[k] = order[k + 1];
                        order[live - 1] = idx;
                        rep.number = NUM_W'(idx + 1);
                        rep.status = ST_HIT;
                        break;
                    end
                end
                if (rep.status == ST_HIT)
                    n_hit++;
                else
                    n_miss++;
            end
            replies_due.push_back(rep);
        endfunction

        // compare one reply of the block with the oldest one due
        task check_reply(input logic [ST_W-1:0] status, input logic [NUM_W-1:0] number);
            reply_t due;
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("reply status=%0d number=%0d with none due",
                                          status, number));
            end else begin
                due = replies_due.pop_front();
                if (status !== due.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, due.status));
                if (number !== due.number)
                    report_mismatch($sformatf("window number %0d, expected %0d",
                                              number, due.number));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_cmd = CMD_ADD;
    logic [COORD_BITS-1:0] i_left_x = '0;
    logic [COORD_BITS-1:0] i_top_y = '0;
    logic [COORD_BITS-1:0] i_right_x = '0;
    logic [COORD_BITS-1:0] i_bottom_y = '0;
    logic [COORD_BITS-1:0] i_point_x = '0;
    logic [COORD_BITS-1:0] i_point_y = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ST_W-1:0]       o_status;
    logic [NUM_W-1:0]      o_window_number;

    window_stack sb = new();

    bit tx_quiet = 1'b0;     // sender offers back to back while set
    int replies_seen = 0;    // replies taken by the receiving side
    int items_sent = 0;

    window_hit_test_raise DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_left_x        (i_left_x),
        .i_top_y         (i_top_y),
        .i_right_x       (i_right_x),
        .i_bottom_y      (i_bottom_y),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_window_number (o_window_number)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard limit, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("** window_hit_test_raise: FAILED **");
        $finish;
    end

    // random rectangle: mostly well formed, some with wholly random corners
    // (which are often empty, left above right or top below bottom)
    function automatic t_rect rand_rect();
        t_rect r;
        int    w;
        int    h;
        if ($urandom_range(4) == 0) begin
            r.x0 = COORD_BITS'($urandom);
            r.y0 = COORD_BITS'($urandom);
            r.x1 = COORD_BITS'($urandom);
            r.y1 = COORD_BITS'($urandom);
        end else begin
            w = $urandom_range(1500);
            h = $urandom_range(1500);
            r.x0 = COORD_BITS'($urandom_range(COORD_MAX - w));
            r.y0 = COORD_BITS'($urandom_range(COORD_MAX - h));
            r.x1 = COORD_BITS'(r.x0 + w);
            r.y1 = COORD_BITS'(r.y0 + h);
        end
        return r;
    endfunction

    // coordinate inside a span, on its edges, or one step outside (wraps at the range)
    function automatic logic [COORD_BITS-1:0] coord_near(input logic [COORD_BITS-1:0] lo,
                                                         input logic [COORD_BITS-1:0] hi);
        case ($urandom_range(9))
            0: return lo;
            1: return hi;
            2: return COORD_BITS'(lo - 1);
            3: return COORD_BITS'(hi + 1);
            default: return COORD_BITS'($urandom_range(hi, lo));
        endcase
    endfunction

    // offer one transaction, with a random gap first, and note it once taken
    task automatic send_item(input logic cmd, input t_rect r,
                             input logic [COORD_BITS-1:0] px,
                             input logic [COORD_BITS-1:0] py);
        if (!tx_quiet && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_left_x   <= r.x0;
        i_top_y    <= r.y0;
        i_right_x  <= r.x1;
        i_bottom_y <= r.y1;
        i_point_x  <= px;
        i_point_y  <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.apply_command(cmd, r, px, py);
        items_sent++;
    endtask

    task automatic add_window(input int x0, input int y0, input int x1, input int y1);
        t_rect r;
        r.x0 = COORD_BITS'(x0);
        r.y0 = COORD_BITS'(y0);
        r.x1 = COORD_BITS'(x1);
        r.y1 = COORD_BITS'(y1);
        // point fields carry noise, the block should ignore them
        send_item(CMD_ADD, r, COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    task automatic click(input int px, input int py);
        // rectangle fields carry noise on a click
        send_item(CMD_CLICK, rand_rect(), COORD_BITS'(px), COORD_BITS'(py));
    endtask

    // sender goes quiet until every reply due has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.replies_due.size() != 0) @(posedge i_clk);
    endtask

    // receiving side: take replies, stall at random, one long hold-off
    initial begin : reply_side
        int hold_left;
        bit hold_done;
        bit rx_quiet;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_reply(o_status, o_window_number);
                replies_seen++;
            end
            // long hold-off while the sender keeps offering
            if (!hold_done && replies_seen >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            rx_quiet = (replies_seen >= 1000 && replies_seen < 1300);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !rx_quiet && ($urandom_range(99) < 14);
            end
        end
    end

    initial begin : stimulus
        int    n;
        int    idx;
        t_rect r;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        click(0, 0);                          // empty stack, nothing to hit
        add_window(100, 200, 300, 400);       // window 1
        click(99, 200);                       // just left of it
        click(301, 400);                      // just right
        click(100, 401);                      // just below
        click(100, 199);                      // just above
        click(100, 200);                      // top-left corner, bounds inclusive
        click(300, 400);                      // bottom-right corner
        add_window(COORD_MAX, 0, 0, COORD_MAX);   // left beyond right: empty
        add_window(0, COORD_MAX, COORD_MAX, 0);   // top beyond bottom: empty
        click(2000, 2000);                    // only the empty windows span it
        add_window(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);  // single pixel
        click(COORD_MAX, COORD_MAX);
        click(COORD_MAX - 1, COORD_MAX);
        add_window(0, 0, COORD_MAX, 0);       // full-width strip on the first row
        add_window(0, 0, 0, COORD_MAX);       // full-height strip on the first column
        click(0, 0);                          // both strips hold it, topmost wins
        click(0, 0);
        click(150, 0);                        // row strip raised over the column strip
        click(0, 300);
        add_window(150, 250, 250, 350);       // overlaps window 1
        click(200, 300);
        click(100, 200);                      // raises window 1 over the newer one
        click(200, 300);                      // now window 1 is on top
        wait_drained();

        // random part: mostly clicks aimed at live windows, adds until full and beyond
        for (n = 0; n < 1500; n++) begin
            tx_quiet = (n >= 600 && n < 900);
            if (n == 1100)
                wait_drained();
            if ($urandom_range(9) == 0) begin
                send_item(CMD_ADD, rand_rect(), COORD_BITS'($urandom), COORD_BITS'($urandom));
            end else begin
                if (sb.live > 0 && $urandom_range(9) < 7) begin
                    idx = $urandom_range(sb.live - 1);
                    px = coord_near(sb.rects[idx].x0, sb.rects[idx].x1);
                    py = coord_near(sb.rects[idx].y0, sb.rects[idx].y1);
                end else begin
                    px = COORD_BITS'($urandom);
                    py = COORD_BITS'($urandom);
                end
                send_item(CMD_CLICK, rand_rect(), px, py);
            end
        end
        i_valid <= 1'b0;

        // drain, then allow for the longest click walk
        for (n = 0; n < 5000 && sb.replies_due.size() != 0; n++)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.replies_due.size() != 0)
            sb.report_mismatch($sformatf("%0d replies never came", sb.replies_due.size()));

        $display("run: %0d transactions sent, %0d replies checked", items_sent, replies_seen);
        $display("run: %0d added, %0d refused on a full stack, %0d hits (%0d raised), %0d misses",
                 sb.n_added, sb.n_full, sb.n_hit, sb.n_raised, sb.n_miss);
        if (sb.errors == 0) begin
            $display("** window_hit_test_raise: PASSED **");
        end else begin
            $display("** window_hit_test_raise: FAILED **");
        end
        $finish;
    end

endmodule
